FILE: src/load_cell_adc_reader_median3_macros.svh
// Assertion macros used by the core block of the load cell reader.
`ifndef LOAD_CELL_ADC_READER_MEDIAN3_MACROS_SVH
`define LOAD_CELL_ADC_READER_MEDIAN3_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcr assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcr assertion failed");

`endif

FILE: src/lcr_pkg.sv
package lcr_pkg;

  localparam int TIMER_W = 20;
  localparam int CFG_W = 20;
  localparam int CFG_IDX_W = 1;
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W = 5;
  localparam int DATA_BITS = 24;
  localparam int NUM_ATTEMPTS = 3;
  localparam int LIM_W = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(100000);
  localparam logic [CFG_W-1:0] GAP_RESET = CFG_W'(15000);
  localparam logic [GAIN_W-1:0] PULSE_TOTAL_RESET = GAIN_W'(25);
  localparam logic [GAIN_W-1:0] MIN_PULSES = GAIN_W'(DATA_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP = 1'b1;

  typedef struct packed {
    logic              start_req;
    logic [GAIN_W-1:0] gain_pulses;
    logic              dout;
  } lcr_item_t;

  typedef struct packed {
    logic                       sck;
    logic                       busy_res;
    logic                       done_res;
    logic                       fail;
    logic signed [SAMPLE_W-1:0] value;
    logic [1:0]                 samples_used;
  } lcr_res_t;

  typedef struct packed {
    logic [CFG_W-1:0] ready_timeout_ticks;
    logic [CFG_W-1:0] gap_ticks;
  } lcr_cfg_t;

  function automatic logic [TIMER_W-1:0] clamp_limit(input logic [CFG_W-1:0] v);
    logic [TIMER_W-1:0] r;
    if (LIM_W'(v) > LIM_W'(TIMER_MAX)) begin
      r = TIMER_MAX;
    end else begin
      r = TIMER_W'(v);
    end
    return r;
  endfunction

  function automatic logic [TIMER_W-1:0] tick_up(input logic [TIMER_W-1:0] t);
    logic [TIMER_W-1:0] r;
    if (t < TIMER_MAX) begin
      r = t + TIMER_W'(1);
    end else begin
      r = t;
    end
    return r;
  endfunction

endpackage

FILE: src/lcr_in_if.sv
interface lcr_in_if
  import lcr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              start_req;
  logic [GAIN_W-1:0] gain_pulses;
  logic              dout;

  modport source (output valid, output start_req, output gain_pulses, output dout,
                  input ready);
  modport sink (input valid, input start_req, input gain_pulses, input dout,
                output ready);
endinterface

FILE: src/lcr_out_if.sv
interface lcr_out_if
  import lcr_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic                       sck;
  logic                       busy_res;
  logic                       done_res;
  logic                       fail;
  logic signed [SAMPLE_W-1:0] value;
  logic [1:0]                 samples_used;

  modport source (output valid, output sck, output busy_res, output done_res,
                  output fail, output value, output samples_used, input ready);
  modport sink (input valid, input sck, input busy_res, input done_res,
                input fail, input value, input samples_used, output ready);
endinterface

FILE: src/load_cell_adc_reader_median3.sv
// Load cell converter reader with median-of-three filtering. Every input transfer is one
// timing tick (start request, gain pulse count, data line level) and yields exactly one
// output transfer with the serial clock level, busy flag and, on the done tick, the filtered
// value, fail flag and number of good samples. One tick is taken per clock cycle while the
// output side keeps up: a tick sits in an input register, the phase sequencer and median
// selection evaluate it combinationally, and the outcome lands in an output register. The
// user must write limits through the register port only while the reader is idle; the
// reader itself does not enforce this.
module load_cell_adc_reader_median3
  import lcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  lcr_in_if.sink               in_ch,
  lcr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic      s1_valid;
  lcr_item_t s1_item;
  logic      out_valid;
  lcr_res_t  out_res;
  lcr_res_t  step_res;
  lcr_cfg_t  cfg;
  logic      adv;
  logic      in_xfer;

  assign adv = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || adv;
  assign in_xfer = in_ch.valid && in_ch.ready;

  lcr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (s1_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      cfg.ready_timeout_ticks <= TIMEOUT_RESET;
      cfg.gap_ticks <= GAP_RESET;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_READY_TIMEOUT: cfg.ready_timeout_ticks <= cfg_data;
          REG_GAP: cfg.gap_ticks <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item.start_req <= in_ch.start_req;
      s1_item.gain_pulses <= in_ch.gain_pulses;
      s1_item.dout <= in_ch.dout;
    end
    if (adv) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.sck = out_res.sck;
  assign out_ch.busy_res = out_res.busy_res;
  assign out_ch.done_res = out_res.done_res;
  assign out_ch.fail = out_res.fail;
  assign out_ch.value = out_res.value;
  assign out_ch.samples_used = out_res.samples_used;

endmodule

FILE: src/lcr_median.sv
module lcr_median
  import lcr_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] s0,
  input  logic signed [SAMPLE_W-1:0] s1,
  input  logic signed [SAMPLE_W-1:0] s2,
  input  logic [1:0]                 count,
  output logic signed [SAMPLE_W-1:0] value
);

  logic signed [SAMPLE_W-1:0] lo01;
  logic signed [SAMPLE_W-1:0] hi01;
  logic signed [SAMPLE_W-1:0] mid;
  logic signed [SAMPLE_W-1:0] med;

  always_comb begin
    lo01 = (s0 > s1) ? s1 : s0;
    hi01 = (s0 > s1) ? s0 : s1;
    mid = (hi01 > s2) ? s2 : hi01;
    med = (lo01 > mid) ? lo01 : mid;
    case (count)
      2'd0: value = '0;
      2'd1: value = s0;
      2'd2: value = hi01;
      default: value = med;
    endcase
  end

endmodule

FILE: src/lcr_core.sv
`include "load_cell_adc_reader_median3_macros.svh"

module lcr_core
  import lcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  lcr_item_t item,
  input  lcr_cfg_t  cfg,
  output lcr_res_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW  = 3'd3,
    PH_GAP  = 3'd4
  } phase_t;

  phase_t             phase, phase_next;
  logic [TIMER_W-1:0] tick_count, tick_count_next;
  logic [GAIN_W-1:0]  pulse_index, pulse_index_next;
  logic [GAIN_W-1:0]  pulse_total, pulse_total_next;
  logic [SAMPLE_W-1:0] shift_word, shift_word_next;
  logic [1:0]         attempt_index, attempt_index_next;
  logic [1:0]         good_count, good_count_next;
  logic signed [SAMPLE_W-1:0] good_samples [NUM_ATTEMPTS];
  logic               sample_we;
  logic [GAIN_W-1:0]  pulse_inc;
  logic [TIMER_W-1:0] tick_inc;
  logic signed [SAMPLE_W-1:0] median;

  lcr_median u_median (
    .s0    (good_samples[0]),
    .s1    (good_samples[1]),
    .s2    (good_samples[2]),
    .count (good_count),
    .value (median)
  );

  always_comb begin
    phase_next = phase;
    tick_count_next = tick_count;
    pulse_index_next = pulse_index;
    pulse_total_next = pulse_total;
    shift_word_next = shift_word;
    attempt_index_next = attempt_index;
    good_count_next = good_count;
    sample_we = 1'b0;
    pulse_inc = pulse_index + GAIN_W'(1);
    tick_inc = tick_up(tick_count);
    res = '0;
    case (phase)
      PH_WAIT: begin
        if (!item.dout) begin
          pulse_index_next = '0;
          shift_word_next = '0;
          phase_next = PH_HIGH;
        end else if (tick_inc >= clamp_limit(cfg.ready_timeout_ticks)) begin
          phase_next = PH_GAP;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_HIGH: begin
        res.sck = 1'b1;
        phase_next = PH_LOW;
      end
      PH_LOW: begin
        if (pulse_index < MIN_PULSES) begin
          shift_word_next = {shift_word[SAMPLE_W-2:0], item.dout};
        end
        pulse_index_next = pulse_inc;
        if (pulse_inc >= pulse_total || pulse_inc == '0) begin
          if (good_count < 2'(NUM_ATTEMPTS)) begin
            sample_we = 1'b1;
            good_count_next = good_count + 2'd1;
          end
          phase_next = PH_GAP;
          tick_count_next = '0;
        end else begin
          phase_next = PH_HIGH;
        end
      end
      PH_GAP: begin
        if (tick_count >= clamp_limit(cfg.gap_ticks)) begin
          if (attempt_index >= 2'(NUM_ATTEMPTS - 1)) begin
            res.done_res = 1'b1;
            res.samples_used = good_count;
            res.fail = (good_count == 2'd0);
            res.value = median;
            phase_next = PH_IDLE;
            attempt_index_next = '0;
          end else begin
            attempt_index_next = attempt_index + 2'd1;
            phase_next = PH_WAIT;
            tick_count_next = '0;
          end
        end else begin
          tick_count_next = tick_inc;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (item.start_req) begin
          pulse_total_next = (item.gain_pulses < MIN_PULSES) ? MIN_PULSES
                                                             : item.gain_pulses;
          attempt_index_next = '0;
          good_count_next = '0;
          tick_count_next = '0;
          pulse_index_next = '0;
          shift_word_next = '0;
          phase_next = PH_WAIT;
        end
      end
    endcase
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_count <= '0;
      pulse_index <= '0;
      pulse_total <= PULSE_TOTAL_RESET;
      shift_word <= '0;
      attempt_index <= '0;
      good_count <= '0;
    end else if (adv) begin
      phase <= phase_next;
      tick_count <= tick_count_next;
      pulse_index <= pulse_index_next;
      pulse_total <= pulse_total_next;
      shift_word <= shift_word_next;
      attempt_index <= attempt_index_next;
      good_count <= good_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sample_we) begin
      good_samples[good_count] <= shift_word_next;
    end
  end

  `LCR_ASSERT_NEXT(a_hold_when_stalled, !adv, $stable(phase) && $stable(tick_count))
  `LCR_ASSERT_NEXT(a_done_goes_idle, adv && res.done_res, phase == PH_IDLE)
  `LCR_ASSERT_NOW(a_fail_is_empty, res.fail, res.samples_used == 2'd0 && res.value == '0)
  `LCR_ASSERT_NOW(a_attempt_range, 1'b1, attempt_index != 2'd3)
  `LCR_ASSERT_NOW(a_pulse_total_range, 1'b1, pulse_total >= MIN_PULSES)

endmodule

FILE: dv/tb_load_cell_adc_reader_median3.sv
`timescale 1ns / 1ps

module tb_load_cell_adc_reader_median3;
  import lcr_pkg::*;

  typedef enum logic [2:0] {RD_IDLE, RD_WAIT, RD_HIGH, RD_LOW, RD_GAP} rd_phase_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lcr_in_if in_ch();
  lcr_out_if out_ch();

  load_cell_adc_reader_median3 dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Reader model state and its copy of the limits.
  rd_phase_t rd_phase;
  logic [TIMER_W-1:0] rd_ticks;
  logic [GAIN_W-1:0] rd_bit_idx;
  logic [GAIN_W-1:0] rd_pulses;
  logic [SAMPLE_W-1:0] rd_shift;
  logic [1:0] rd_attempt;
  logic [1:0] rd_good;
  logic [SAMPLE_W-1:0] rd_samples [3];
  logic [CFG_W-1:0] rd_timeout;
  logic [CFG_W-1:0] rd_gap;

  lcr_item_t tick_queue [$];
  lcr_res_t due_results [$];
  lcr_item_t next_tick;
  lcr_res_t got;
  lcr_res_t want;

  int ticks_queued = 0;
  int ticks_accepted = 0;
  int results_seen = 0;
  int errors = 0;
  int reads_done = 0;
  int reads_failed = 0;
  int reg_writes = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit pressure_arm = 1'b0;
  logic rx_hold = 1'b0;

  function automatic lcr_res_t step_reader(input logic start, input logic [GAIN_W-1:0] gain,
                                           input logic d);
    lcr_res_t r;
    logic signed [SAMPLE_W-1:0] a, b, c;
    r = '0;
    case (rd_phase)
      RD_WAIT: begin
        if (!d) begin
          rd_bit_idx = '0;
          rd_shift = '0;
          rd_phase = RD_HIGH;
        end else begin
          if (rd_ticks != TIMER_MAX) rd_ticks = rd_ticks + 1'b1;
          if (rd_ticks >= rd_timeout) begin
            rd_phase = RD_GAP;
            rd_ticks = '0;
          end
        end
      end
      RD_HIGH: begin
        r.sck = 1'b1;
        rd_phase = RD_LOW;
      end
      RD_LOW: begin
        if (rd_bit_idx < DATA_BITS) rd_shift = {rd_shift[SAMPLE_W-2:0], d};
        rd_bit_idx = rd_bit_idx + 1'b1;
        if (rd_bit_idx >= rd_pulses || rd_bit_idx == 0) begin
          if (rd_good < NUM_ATTEMPTS) begin
            rd_samples[rd_good] = rd_shift;
            rd_good = rd_good + 2'd1;
          end
          rd_phase = RD_GAP;
          rd_ticks = '0;
        end else begin
          rd_phase = RD_HIGH;
        end
      end
      RD_GAP: begin
        if (rd_ticks >= rd_gap) begin
          rd_attempt = rd_attempt + 2'd1;
          if (rd_attempt >= NUM_ATTEMPTS) begin
            r.done_res = 1'b1;
            r.samples_used = rd_good;
            a = rd_samples[0];
            b = rd_samples[1];
            c = rd_samples[2];
            case (rd_good)
              2'd0: r.fail = 1'b1;
              2'd1: r.value = a;
              2'd2: r.value = (a > b) ? a : b;
              default: begin
                if (a > b) r.value = (b > c) ? b : ((a > c) ? c : a);
                else r.value = (a > c) ? a : ((b > c) ? c : b);
              end
            endcase
            reads_done++;
            if (rd_good == 0) reads_failed++;
            rd_phase = RD_IDLE;
            rd_attempt = '0;
          end else begin
            rd_phase = RD_WAIT;
            rd_ticks = '0;
          end
        end else if (rd_ticks != TIMER_MAX) begin
          rd_ticks = rd_ticks + 1'b1;
        end
      end
      default: begin
        rd_phase = RD_IDLE;
        if (start) begin
          rd_pulses = (gain < MIN_PULSES) ? MIN_PULSES : gain;
          rd_attempt = '0;
          rd_good = '0;
          rd_ticks = '0;
          rd_bit_idx = '0;
          rd_shift = '0;
          rd_phase = RD_WAIT;
        end
      end
    endcase
    r.busy_res = (rd_phase != RD_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      rd_phase = RD_IDLE;
      rd_ticks = '0;
      rd_bit_idx = '0;
      rd_pulses = PULSE_TOTAL_RESET;
      rd_shift = '0;
      rd_attempt = '0;
      rd_good = '0;
      rd_samples[0] = '0;
      rd_samples[1] = '0;
      rd_samples[2] = '0;
      rd_timeout = TIMEOUT_RESET;
      rd_gap = GAP_RESET;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(step_reader(in_ch.start_req, in_ch.gain_pulses, in_ch.dout));
        ticks_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_tick = tick_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.start_req <= next_tick.start_req;
          in_ch.gain_pulses <= next_tick.gain_pulses;
          in_ch.dout <= next_tick.dout;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.sck = out_ch.sck;
        got.busy_res = out_ch.busy_res;
        got.done_res = out_ch.done_res;
        got.fail = out_ch.fail;
        got.value = out_ch.value;
        got.samples_used = out_ch.samples_used;
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected transfer: sck=%b busy=%b done=%b fail=%b value=%0d used=%0d",
                     got.sck, got.busy_res, got.done_res, got.fail, got.value,
                     got.samples_used);
          end
        end else begin
          want = due_results.pop_front();
          if (got.sck !== want.sck || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.fail !== want.fail ||
              got.value !== want.value || got.samples_used !== want.samples_used) begin
            errors++;
            if (errors <= 10) begin
              $display("tick %0d: expected sck=%b busy=%b done=%b fail=%b value=%0d used=%0d",
                       results_seen, want.sck, want.busy_res, want.done_res, want.fail,
                       want.value, want.samples_used);
              $display("tick %0d:      got sck=%b busy=%b done=%b fail=%b value=%0d used=%0d",
                       results_seen, got.sck, got.busy_res, got.done_res, got.fail,
                       got.value, got.samples_used);
            end
          end
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // The receiver stops for a long stretch while the sender keeps offering ticks.
  initial begin
    wait (pressure_arm);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void push_tick(input logic start, input logic [GAIN_W-1:0] gain,
                                    input logic d);
    lcr_item_t t;
    t.start_req = start;
    t.gain_pulses = gain;
    t.dout = d;
    tick_queue.push_back(t);
    ticks_queued++;
  endfunction

  function automatic void busy_tick(input logic d);
    push_tick(1'($urandom_range(1)), GAIN_W'($urandom_range(31)), d);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_word();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_READY_TIMEOUT) rd_timeout = data;
    else rd_gap = data;
    reg_writes++;
  endtask

  // Queues one whole read: a start tick, three attempts and their gaps. Each attempt either
  // gets a sample (dout drops before the limit, then the word is shifted in) or times out.
  function automatic void queue_read(input logic [GAIN_W-1:0] gain, input logic [2:0] ok,
                                     input logic [SAMPLE_W-1:0] w0, input logic [SAMPLE_W-1:0] w1,
                                     input logic [SAMPLE_W-1:0] w2, input bit late);
    logic [SAMPLE_W-1:0] w [3];
    int pulses;
    int hold;
    w[0] = w0;
    w[1] = w1;
    w[2] = w2;
    pulses = (gain < MIN_PULSES) ? DATA_BITS : gain;
    push_tick(1'b1, gain, 1'($urandom_range(1)));
    for (int i = 0; i < NUM_ATTEMPTS; i++) begin
      if (ok[i]) begin
        if (rd_timeout == 0) hold = 0;
        else if (late) hold = rd_timeout - 1;
        else hold = $urandom_range(rd_timeout > 6 ? 5 : rd_timeout - 1);
        repeat (hold) busy_tick(1'b1);
        busy_tick(1'b0);
        for (int p = 0; p < pulses; p++) begin
          busy_tick(1'($urandom_range(1)));
          busy_tick(p < DATA_BITS ? w[i][DATA_BITS-1-p] : 1'($urandom_range(1)));
        end
      end else begin
        repeat (rd_timeout == 0 ? 1 : rd_timeout) busy_tick(1'b1);
      end
      repeat (rd_gap + 1) busy_tick(1'($urandom_range(1)));
    end
  endfunction

  task automatic settle();
    forever begin
      while (results_seen < ticks_queued) @(posedge clk);
      if (rd_phase == RD_IDLE) break;
      repeat (16) push_tick(1'b0, GAIN_W'($urandom_range(31)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [2:0] ok;
    logic [GAIN_W-1:0] gain;
    in_ch.valid = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.gain_pulses = '0;
    in_ch.dout = 1'b1;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 16;
    rx_idle_pct = 64;
    write_reg(REG_READY_TIMEOUT, 20'd3);
    write_reg(REG_GAP, 20'd0);
    queue_read(5'd25, 3'b111, 24'h7FFFFF, 24'h800000, 24'h000000, 1'b1);
    queue_read(5'd26, 3'b011, 24'h800001, 24'hFFFFFF, 24'h000000, 1'b0);
    queue_read(5'd27, 3'b100, 24'h000000, 24'h000000, 24'h5A5A5A, 1'b0);
    queue_read(5'd0, 3'b000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    settle();
    write_reg(REG_READY_TIMEOUT, 20'd0);
    write_reg(REG_GAP, 20'd1);
    queue_read(5'd24, 3'b101, 24'h000001, 24'h000000, 24'hFFFFFE, 1'b0);
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 16 : (seg < 4) ? 64 : 0;
      rx_idle_pct = (seg < 2) ? 64 : (seg < 4) ? 16 : 0;
      case (seg)
        0: begin
          write_reg(REG_READY_TIMEOUT, 20'd1);
          write_reg(REG_GAP, 20'd0);
        end
        1: begin
          write_reg(REG_READY_TIMEOUT, CFG_W'($urandom_range(12)));
          write_reg(REG_GAP, CFG_W'($urandom_range(6)));
        end
        2: begin
          write_reg(REG_READY_TIMEOUT, '1);
          write_reg(REG_GAP, CFG_W'($urandom_range(3)));
        end
        3: begin
          write_reg(REG_GAP, '1);
          repeat (20) push_tick(1'b0, GAIN_W'($urandom_range(31)), 1'($urandom_range(1)));
          settle();
          write_reg(REG_READY_TIMEOUT, 20'd0);
          write_reg(REG_GAP, CFG_W'($urandom_range(1, 4)));
        end
        4: begin
          write_reg(REG_READY_TIMEOUT, CFG_W'($urandom_range(1, 12)));
          write_reg(REG_GAP, CFG_W'($urandom_range(8)));
        end
        default: begin
          write_reg(REG_READY_TIMEOUT, CFG_W'($urandom_range(2, 20)));
          write_reg(REG_GAP, 20'd0);
        end
      endcase
      if (seg == 4) pressure_arm = 1'b1;
      for (int r = 0; r < 1; r++) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(4, 30))
            push_tick($urandom_range(3) == 0, GAIN_W'($urandom_range(31)),
                      1'($urandom_range(1)));
          settle();
        end else begin
          gain = ($urandom_range(3) != 0) ? GAIN_W'($urandom_range(25, 27))
                                          : GAIN_W'($urandom_range(31));
          for (int i = 0; i < NUM_ATTEMPTS; i++) ok[i] = ($urandom_range(3) != 0);
          if ($urandom_range(7) == 0) ok = 3'b000;
          if (rd_timeout > 4096) ok = 3'b111;
          queue_read(gain, ok, rand_word(), rand_word(), rand_word(),
                     rd_timeout <= 12 && $urandom_range(3) == 0);
          repeat ($urandom_range(3))
            push_tick(1'b0, GAIN_W'($urandom_range(31)), 1'($urandom_range(1)));
        end
      end
      settle();
    end

    repeat (20) @(posedge clk);
    errors += due_results.size();
    $display("%0d ticks sent and %0d results checked over %0d register writes.",
             ticks_accepted, results_seen, reg_writes);
    $display("%0d filtered reads finished, %0d of them failed.", reads_done, reads_failed);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
